### hw/rtl/masked_aes128_encrypt_defines.svh
// Assertion macros for the masked AES-128 block.
`ifndef MASKED_AES128_ENCRYPT_DEFINES_SVH
`define MASKED_AES128_ENCRYPT_DEFINES_SVH
`define MAES_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MAES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### hw/rtl/maes_pkg.sv
package maes_pkg;

    localparam int unsigned RegKeyHigh  = 0;
    localparam int unsigned RegKeyLow   = 1;
    localparam int unsigned RegInMask   = 2;
    localparam int unsigned RegOutMask  = 3;
    localparam int unsigned RegRowMasks = 4;
    localparam int unsigned CfgIdxW     = 3;
    localparam int unsigned CfgDataW    = 64;
    localparam int unsigned KeyBytes    = 176;
    localparam int unsigned LastKeyBase = 160;
    localparam int unsigned Rounds      = 10;

    typedef logic [7:0] t_byte;

    function automatic t_byte sbox(input t_byte x);
        t_byte tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tbl[x];
    endfunction

    function automatic t_byte rcon(input logic [3:0] r);
        case (r)
            4'd0: return 8'h01;
            4'd1: return 8'h02;
            4'd2: return 8'h04;
            4'd3: return 8'h08;
            4'd4: return 8'h10;
            4'd5: return 8'h20;
            4'd6: return 8'h40;
            4'd7: return 8'h80;
            4'd8: return 8'h1b;
            4'd9: return 8'h36;
            default: return 8'h00;
        endcase
    endfunction

    function automatic t_byte xt(input t_byte v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // MixColumns of one column, byte 0 in bits 31:24.
    function automatic logic [31:0] mix_col(input logic [31:0] a);
        t_byte a0, a1, a2, a3;
        a0 = a[31:24];
        a1 = a[23:16];
        a2 = a[15:8];
        a3 = a[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    typedef struct packed {
        logic       sbox_we;
        t_byte      sbox_addr;
        t_byte      sbox_data;
        logic       key_we;
        logic [7:0] key_addr;
        t_byte      key_data;
        logic       done;
    } t_build;

endpackage

### hw/rtl/maes_builder.sv
module maes_builder import maes_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_key_high,
    input  logic [63:0]  i_key_low,
    input  t_byte        i_in_mask,
    input  t_byte        i_out_mask,
    input  logic [31:0]  i_mixed,
    output t_build       o_build
);

    typedef enum logic [1:0] {ST_IDLE, ST_SBOX, ST_KEY} t_state;

    t_state         r_state;
    logic [8:0]     r_cnt;
    logic [127:0]   r_win;
    logic [3:0]     r_rnd;
    t_build         r_out;

    logic [31:0] w_t;
    logic [31:0] w_w0, w_w1, w_w2, w_w3;
    logic [127:0] w_next;
    logic [3:0]   w_pos;
    t_byte        w_kb, w_q;

    always_comb begin
        w_t = {sbox(r_win[23:16]) ^ rcon(r_rnd), sbox(r_win[15:8]),
               sbox(r_win[7:0]), sbox(r_win[31:24])};
        w_w0 = r_win[127:96] ^ w_t;
        w_w1 = r_win[95:64] ^ w_w0;
        w_w2 = r_win[63:32] ^ w_w1;
        w_w3 = r_win[31:0] ^ w_w2;
        w_next = {w_w0, w_w1, w_w2, w_w3};
        w_pos = r_cnt[3:0];
        w_kb = r_win[8'd127 - {w_pos[3:0], 3'b000} -: 8];
        w_q = i_mixed[8'd31 - {3'b000, w_pos[1:0], 3'b000} -: 8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out <= '0;
            r_cnt <= '0;
            r_rnd <= '0;
        end else begin
            r_out <= '0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_SBOX;
                        r_cnt <= '0;
                    end
                end
                ST_SBOX: begin
                    r_out.sbox_we <= 1'b1;
                    r_out.sbox_addr <= r_cnt[7:0] ^ i_in_mask;
                    r_out.sbox_data <= sbox(r_cnt[7:0]) ^ i_out_mask;
                    r_cnt <= r_cnt + 9'd1;
                    if (r_cnt == 9'd255) begin
                        r_state <= ST_KEY;
                        r_cnt <= '0;
                        r_rnd <= '0;
                        r_win <= {i_key_high, i_key_low};
                    end
                end
                ST_KEY: begin
                    // One key byte per cycle; the window rolls every 16 bytes.
                    r_out.key_we <= 1'b1;
                    r_out.key_addr <= r_cnt[7:0];
                    r_out.key_data <= (r_cnt < 9'(LastKeyBase)) ?
                        (w_kb ^ i_in_mask ^ w_q) : (w_kb ^ i_out_mask);
                    r_cnt <= r_cnt + 9'd1;
                    if (w_pos[3:0] == 4'd15) begin
                        r_win <= w_next;
                        r_rnd <= r_rnd + 4'd1;
                    end
                    if (r_cnt == 9'(KeyBytes - 1)) begin
                        r_state <= ST_IDLE;
                        r_out.done <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_build = r_out;

endmodule

### hw/rtl/masked_aes128_encrypt.sv
// The first word after reset or a write to a used configuration register waits for the
// table build (start handshake, 256 S-box entries, then 176 key bytes, one write per cycle).
// The word rate is set by the single S-box and key read ports; a new word is accepted only
// once the last result word has been loaded.
// Reset clears control state and configuration; memories are undefined until built.
module masked_aes128_encrypt import maes_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [63:0]         i_plaintext_high,
    input  logic [63:0]         i_plaintext_low,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [63:0]         o_ciphertext_high,
    output logic [63:0]         o_ciphertext_low
);
`include "masked_aes128_encrypt_defines.svh"

    typedef enum logic [2:0] {ST_IDLE, ST_BUILD, ST_SUB, ST_MIX, ST_FIN, ST_OUT} t_state;

    logic [63:0] r_key_high, r_key_low;
    t_byte       r_in_mask, r_out_mask;
    logic [31:0] r_row_masks, r_mixed;
    logic        r_ready, r_start;
    t_state      r_state;
    logic [127:0] r_blk;
    logic [3:0]  r_round;
    logic [4:0]  r_idx;
    logic        r_valid;
    logic [127:0] r_res;

    t_byte r_sbox_mem [256];
    t_byte r_key_mem [KeyBytes];
    t_byte r_sbox_q, r_key_q;
    t_byte n_sbox_addr;
    logic [7:0] n_key_addr;
    t_build w_build;

    maes_builder u_builder (
        .i_clk, .i_rst_n, .i_start(r_start),
        .i_key_high(r_key_high), .i_key_low(r_key_low),
        .i_in_mask(r_in_mask), .i_out_mask(r_out_mask),
        .i_mixed(r_mixed), .o_build(w_build)
    );

    always_ff @(posedge i_clk) begin
        if (w_build.sbox_we) r_sbox_mem[w_build.sbox_addr] <= w_build.sbox_data;
        r_sbox_q <= r_sbox_mem[n_sbox_addr];
        if (w_build.key_we) r_key_mem[w_build.key_addr] <= w_build.key_data;
        r_key_q <= r_key_mem[n_key_addr];
    end

    // Byte pipeline: key address at step k, S-box address for byte k-1, write-back of k-2.
    logic [3:0]   w_rd, w_wr;
    t_byte        w_sb, w_mm;
    logic [127:0] w_mixed_blk, w_shift;
    logic         w_last;
    logic         w_load;

    always_comb begin
        w_rd = r_idx[3:0] - 4'd1;
        w_wr = r_idx[3:0] - 4'd2;
        w_sb = r_blk[8'd127 - {w_rd, 3'b000} -: 8];
        w_mm = r_mixed[8'd31 - {3'b000, w_rd[1:0], 3'b000} -: 8];
        w_last = (r_round == 4'(Rounds - 1));
        n_sbox_addr = w_sb ^ w_mm ^ r_key_q;
        if (r_state == ST_FIN) begin
            n_key_addr = 8'(LastKeyBase) + {4'b0000, r_idx[3:0]};
        end else begin
            n_key_addr = {r_round, 4'b0000} + {4'b0000, r_idx[3:0]};
        end
        // Unmask, add row masks, mix diagonals, re-mask, shift rows; the last round only shifts.
        w_mixed_blk = r_blk;
        for (int c = 0; c < 4; c++) begin
            logic [31:0] a, o;
            for (int rw = 0; rw < 4; rw++) begin
                a[31-8*rw -: 8] = r_blk[127-8*(((c+rw)%4)*4+rw) -: 8] ^ r_out_mask
                                  ^ r_row_masks[31-8*rw -: 8];
            end
            o = mix_col(a);
            for (int rw = 0; rw < 4; rw++) begin
                w_mixed_blk[127-8*(((c+rw)%4)*4+rw) -: 8] = o[31-8*rw -: 8]
                                                            ^ r_mixed[31-8*rw -: 8];
            end
        end
        if (w_last) w_mixed_blk = r_blk;
        w_shift = w_mixed_blk;
        for (int c = 0; c < 4; c++) begin
            for (int rw = 0; rw < 4; rw++) begin
                w_shift[127-8*(c*4+rw) -: 8] = w_mixed_blk[127-8*(((c+rw)%4)*4+rw) -: 8];
            end
        end
    end

    assign w_load = (r_state == ST_OUT) && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0; r_key_low <= '0;
            r_in_mask <= '0; r_out_mask <= '0; r_row_masks <= '0;
            r_mixed <= '0; r_ready <= 1'b0; r_start <= 1'b0;
            r_state <= ST_IDLE; r_valid <= 1'b0;
            r_round <= '0; r_idx <= '0;
            r_res <= '0;
        end else begin
            r_start <= 1'b0;
            if (w_load) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
            if (i_cfg_we && i_cfg_idx <= CfgIdxW'(RegRowMasks)) begin
                r_ready <= 1'b0;
                case (i_cfg_idx)
                    CfgIdxW'(RegKeyHigh):  r_key_high <= i_cfg_data;
                    CfgIdxW'(RegKeyLow):   r_key_low <= i_cfg_data;
                    CfgIdxW'(RegInMask):   r_in_mask <= i_cfg_data[7:0];
                    CfgIdxW'(RegOutMask):  r_out_mask <= i_cfg_data[7:0];
                    CfgIdxW'(RegRowMasks): r_row_masks <= i_cfg_data[31:0];
                    default: ;
                endcase
            end else if (r_state == ST_BUILD && w_build.done) begin
                r_ready <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_blk <= {i_plaintext_high, i_plaintext_low};
                        r_round <= '0; r_idx <= '0;
                        if (r_ready) r_state <= ST_SUB;
                        else begin
                            r_mixed <= mix_col(r_row_masks);
                            r_start <= 1'b1;
                            r_state <= ST_BUILD;
                        end
                    end
                end
                ST_BUILD: begin
                    if (w_build.done) r_state <= ST_SUB;
                end
                ST_SUB: begin
                    if (r_idx >= 5'd2) r_blk[8'd127 - {w_wr, 3'b000} -: 8] <= r_sbox_q;
                    if (r_idx == 5'd17) begin
                        r_idx <= '0;
                        r_state <= ST_MIX;
                    end else begin
                        r_idx <= r_idx + 5'd1;
                    end
                end
                ST_MIX: begin
                    r_blk <= w_shift;
                    if (w_last) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_round <= r_round + 4'd1;
                        r_state <= ST_SUB;
                    end
                end
                ST_FIN: begin
                    // The last round key is added one byte per cycle through the key port.
                    if (r_idx != 5'd0) r_blk[8'd127 - {w_rd, 3'b000} -: 8] <= w_sb ^ r_key_q;
                    if (r_idx == 5'd16) begin
                        r_idx <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_idx <= r_idx + 5'd1;
                    end
                end
                ST_OUT: begin
                    if (w_load) begin
                        r_res <= r_blk;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_ciphertext_high = r_res[127:64];
    assign o_ciphertext_low = r_res[63:0];

    `MAES_ASSERT_IMPL(a_build_only_when_building, i_clk, i_rst_n,
        w_build.sbox_we || w_build.key_we, r_state == ST_BUILD,
        "table write outside build")
    `MAES_ASSERT_NEXT(a_result_held, i_clk, i_rst_n,
        o_valid && i_stall,
        o_valid && $stable(o_ciphertext_high) && $stable(o_ciphertext_low),
        "result word changed while stalled")
    `MAES_ASSERT_IMPL(a_round_range, i_clk, i_rst_n,
        1'b1, r_round < 4'(Rounds), "round counter out of range")
endmodule

### dv/masked_aes128_encrypt_checker.sv
`timescale 1ns / 100ps

module masked_aes128_encrypt_checker import maes_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_valid,
    input  logic                i_in_stall,
    input  logic [63:0]         i_plaintext_high,
    input  logic [63:0]         i_plaintext_low,
    input  logic                i_out_valid,
    input  logic                i_stall,
    input  logic [63:0]         i_ciphertext_high,
    input  logic [63:0]         i_ciphertext_low,
    output int                  o_fails,
    output int                  o_pending,
    output int                  o_checked
);

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_block;

    t_byte       sub_tbl [256];
    t_byte       key_sched [176];
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    t_block      cipher_q [$];

    function automatic t_byte gdbl(input t_byte v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_byte gmul(input t_byte a, input t_byte b);
        t_byte p;
        p = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p ^= a;
            a = gdbl(a);
        end
        return p;
    endfunction

    // The substitution table is derived from the field inverse and the affine map.
    initial begin
        t_byte inv;
        t_byte b;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h01;
            for (int k = 0; k < 254; k++) inv = gmul(inv, t_byte'(x));
            if (x == 0) inv = 8'h00;
            b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sub_tbl[x] = b;
        end
    end

    function automatic void expand_key();
        t_byte t [4];
        t_byte f;
        t_byte rc;
        rc = 8'h01;
        for (int i = 0; i < 8; i++) begin
            key_sched[i]     = key_hi[63-8*i -: 8];
            key_sched[i + 8] = key_lo[63-8*i -: 8];
        end
        for (int i = 16; i < 176; i += 4) begin
            for (int j = 0; j < 4; j++) t[j] = key_sched[i - 4 + j];
            if (i % 16 == 0) begin
                f = t[0];
                t[0] = sub_tbl[t[1]] ^ rc;
                t[1] = sub_tbl[t[2]];
                t[2] = sub_tbl[t[3]];
                t[3] = sub_tbl[f];
                rc = gdbl(rc);
            end
            for (int j = 0; j < 4; j++) key_sched[i + j] = key_sched[i - 16 + j] ^ t[j];
        end
    endfunction

    // Plain AES-128; the masks cancel inside the block so they do not appear here.
    function automatic t_block cipher_block(input logic [63:0] hi, input logic [63:0] lo);
        t_byte  s [16];
        t_byte  t [16];
        t_byte  a [4];
        t_block r;
        for (int i = 0; i < 8; i++) begin
            s[i]     = hi[63-8*i -: 8] ^ key_sched[i];
            s[i + 8] = lo[63-8*i -: 8] ^ key_sched[i + 8];
        end
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    t[c*4 + w] = sub_tbl[s[((c + w) % 4)*4 + w]];
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    for (int w = 0; w < 4; w++) a[w] = t[c*4 + w];
                    t[c*4]     = gdbl(a[0]) ^ gdbl(a[1]) ^ a[1] ^ a[2] ^ a[3];
                    t[c*4 + 1] = a[0] ^ gdbl(a[1]) ^ gdbl(a[2]) ^ a[2] ^ a[3];
                    t[c*4 + 2] = a[0] ^ a[1] ^ gdbl(a[2]) ^ gdbl(a[3]) ^ a[3];
                    t[c*4 + 3] = gdbl(a[0]) ^ a[0] ^ a[1] ^ a[2] ^ gdbl(a[3]);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ key_sched[rnd*16 + i];
        end
        for (int i = 0; i < 8; i++) begin
            r.hi[63-8*i -: 8] = s[i];
            r.lo[63-8*i -: 8] = s[i + 8];
        end
        return r;
    endfunction

    initial begin
        o_fails = 0;
        o_checked = 0;
        key_hi = '0;
        key_lo = '0;
        #1 expand_key();
    end

    assign o_pending = cipher_q.size();

    // Inputs change only at rising edges, so the falling edge sees what the next edge accepts.
    always @(negedge i_clk) begin
        t_block want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_idx == RegKeyHigh) key_hi = i_cfg_data;
                if (i_cfg_idx == RegKeyLow) key_lo = i_cfg_data;
                expand_key();
            end
            if (i_valid && !i_in_stall)
                cipher_q.push_back(cipher_block(i_plaintext_high, i_plaintext_low));
            if (i_out_valid && !i_stall) begin
                if (cipher_q.size() == 0) begin
                    $error("result word with nothing expected: %h %h",
                           i_ciphertext_high, i_ciphertext_low);
                    o_fails++;
                end else begin
                    want = cipher_q.pop_front();
                    o_checked++;
                    if (i_ciphertext_high !== want.hi) begin
                        $error("ciphertext_high expected %h actual %h", want.hi,
                               i_ciphertext_high);
                        o_fails++;
                    end
                    if (i_ciphertext_low !== want.lo) begin
                        $error("ciphertext_low expected %h actual %h", want.lo,
                               i_ciphertext_low);
                        o_fails++;
                    end
                end
            end
        end
    end

endmodule

### dv/masked_aes128_encrypt_tb.sv
`timescale 1ns / 100ps

module masked_aes128_encrypt_tb import maes_pkg::*;;

    localparam int CycleLimit = 2000000;
    localparam int PhaseWords = 220;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                i_valid;
    logic                o_stall;
    logic [63:0]         i_plaintext_high;
    logic [63:0]         i_plaintext_low;
    logic                o_valid;
    logic                i_stall;
    logic [63:0]         o_ciphertext_high;
    logic [63:0]         o_ciphertext_low;

    int fails;
    int pending;
    int checked;
    int words_sent;
    int cfg_writes;
    int cycles;
    int long_hold;
    bit quiet;

    masked_aes128_encrypt dut (.*);

    masked_aes128_encrypt_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_in_stall(o_stall), .i_plaintext_high, .i_plaintext_low,
        .i_out_valid(o_valid), .i_stall, .i_ciphertext_high(o_ciphertext_high),
        .i_ciphertext_low(o_ciphertext_low),
        .o_fails(fails), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CycleLimit) begin
                $display("timeout after %0d cycles", cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver side: random stall bursts, one long hold-off on request, none when quiet.
    initial begin
        int hold;
        hold = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold > 0) begin
                hold = long_hold;
                long_hold = 0;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                hold--;
            end else if (quiet || $urandom_range(5, 0) != 0) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b1;
                hold = $urandom_range(7, 0);
            end
        end
    end

    task automatic cfg_write(input int idx, input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CfgIdxW'(idx);
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    task automatic configure(input logic [63:0] kh, input logic [63:0] kl,
                             input logic [63:0] im, input logic [63:0] om,
                             input logic [63:0] rm);
        cfg_write(RegKeyHigh, kh);
        cfg_write(RegKeyLow, kl);
        cfg_write(RegInMask, im);
        cfg_write(RegOutMask, om);
        cfg_write(RegRowMasks, rm);
    endtask

    task automatic send_word(input logic [63:0] hi, input logic [63:0] lo);
        bit taken;
        if (!quiet && $urandom_range(4, 0) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_plaintext_high <= hi;
        i_plaintext_low <= lo;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9, 0))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(63, 0);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        logic [63:0] ones;
        ones = '1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_plaintext_high = '0;
        i_plaintext_low = '0;
        words_sent = 0;
        cfg_writes = 0;
        long_hold = 0;
        quiet = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Standard test vector key with no masking, then the same words fully masked.
        configure(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 0, 0, 0);
        send_word(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_word('0, '0);
        send_word(ones, ones);
        send_word(64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a);
        send_word(64'h8000000000000000, 64'h0000000000000001);
        drain();
        // Mask registers take only their low bits; upper data bits must be dropped.
        configure(ones, ones, ones, ones, ones);
        send_word(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_word('0, '0);
        send_word(ones, ones);
        drain();
        configure('0, '0, 64'hffffffffffffff5a, 64'hffffffffffffffa5, 64'h12345678_9abcdef0);
        send_word('0, '0);
        send_word(ones, '0);
        drain();
        // Writes to unused register slots must leave the block unchanged.
        for (int idx = RegRowMasks + 1; idx < (1 << CfgIdxW); idx++)
            cfg_write(idx, {$urandom, $urandom});
        send_word(64'h0123456789abcdef, 64'hfedcba9876543210);
        send_word('0, ones);
        drain();
        // A single register write forces a rebuild of the tables.
        cfg_write(RegOutMask, 64'h3c);
        send_word(64'h0011223344556677, 64'h8899aabbccddeeff);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: configure(ones, ones, 0, 0, 0);
                1: configure('0, '0, 8'hff, 8'hff, 32'hffffffff);
                5: cfg_write(RegInMask, $urandom_range(255, 0));
                6: cfg_write(RegRowMasks, $urandom);
                default: configure({$urandom, $urandom}, {$urandom, $urandom},
                                   $urandom_range(255, 0), $urandom_range(255, 0), $urandom);
            endcase
            if (ph == 3) long_hold = 1500;
            if (ph == 7) quiet = 1'b1;
            for (int n = 0; n < PhaseWords; n++) send_word(rand_word(), rand_word());
            drain();
        end

        repeat (400) @(posedge i_clk);
        $display("ran %0d plaintext words and %0d register writes; %0d ciphertexts checked",
                 words_sent, cfg_writes, checked);
        $display("covered mask extremes, key extremes, unused register slots and a long stall");
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
